/* rtl/ipv4dq_pkg.sv */
// ----------------------------------------------------------------------------
// ipv4dq_pkg
// Shared types and codes for the dotted-quad address parser.
// ----------------------------------------------------------------------------
package ipv4dq_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned DIGIT_W  = 5;  // 0..15 digit value, 16 = not a digit
  localparam int unsigned ERR_W    = 3;
  localparam int unsigned OCTET_W  = 8;
  localparam int unsigned OCTETS   = 4;
  localparam int unsigned M_DATA_W = 40; // error code + four octets, byte padded

  localparam logic [DIGIT_W-1:0] NOT_DIGIT = 5'd16;

  localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
  localparam logic [ERR_W-1:0] ERR_NOTDIGIT = 3'd1;
  localparam logic [ERR_W-1:0] ERR_BADCHAR  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_RANGE    = 3'd3;
  localparam logic [ERR_W-1:0] ERR_FEW      = 3'd4;
  localparam logic [ERR_W-1:0] ERR_MANY     = 3'd5;

  // classified character word passed from front to back
  typedef struct packed {
    logic               term;   // terminator (flagged or zero byte)
    logic               dot;
    logic               is_x;   // 'x' or 'X'
    logic [DIGIT_W-1:0] digit;
  } item_t;

endpackage

/* rtl/ipv4_dotted_quad_parser.sv */
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser
// Dotted-quad address checker: one character per word in, one verdict out.
// ----------------------------------------------------------------------------
// Takes one character word per cycle while the queue has room. A word
// carrying s_tlast, or a zero byte, closes the string, and one verdict word
// follows from the verdict register. The front classifies each character
// and writes it to a short queue; the back drains one word a cycle into the
// token state. Only a terminator waits, and then only while the verdict
// register holds an untaken result; the queue absorbs that stall until full.
module ipv4_dotted_quad_parser #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // [7:0] ch
  input  logic                            s_tlast,  // end_of_string
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ipv4dq_pkg::M_DATA_W-1:0] m_tdata,  // [2:0] error_code,
                                                    // [10:3] octet_a, [18:11] octet_b,
                                                    // [26:19] octet_c, [34:27] octet_d
  output logic                            m_tuser   // is_valid
);

  logic              push;
  ipv4dq_pkg::item_t push_item;
  logic              q_full;
  logic              pop;
  logic              head_valid;
  ipv4dq_pkg::item_t head_item;

  ipv4dq_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  ipv4dq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  ipv4dq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

/* rtl/ipv4dq_front.sv */
// ----------------------------------------------------------------------------
// ipv4dq_front
// Accepts character words and classifies them for the back end.
// ----------------------------------------------------------------------------
module ipv4dq_front (
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,  // [7:0] ch
  input  logic                         s_tlast,  // end_of_string
  output logic                         push,
  output ipv4dq_pkg::item_t            push_item,
  input  logic                         q_full
);

  logic [ipv4dq_pkg::CHAR_W-1:0] ch;

  assign ch       = s_tdata;
  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    push_item.term = s_tlast || (ch == 8'h00);
    push_item.dot  = (ch == 8'h2e);
    push_item.is_x = (ch == 8'h78) || (ch == 8'h58);
    if (ch >= 8'h30 && ch <= 8'h39) begin
      push_item.digit = 5'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      push_item.digit = 5'(ch - 8'h57);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      push_item.digit = 5'(ch - 8'h37);
    end else begin
      push_item.digit = ipv4dq_pkg::NOT_DIGIT;
    end
  end

endmodule

/* rtl/ipv4dq_queue.sv */
// ----------------------------------------------------------------------------
// ipv4dq_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module ipv4dq_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ipv4dq_pkg::item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output ipv4dq_pkg::item_t head_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ipv4dq_pkg::item_t  mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/ipv4dq_back.sv */
// ----------------------------------------------------------------------------
// ipv4dq_back
// Token and radix tracking, value accumulation and the verdict register.
// ----------------------------------------------------------------------------
module ipv4dq_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  ipv4dq_pkg::item_t             head_item,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ipv4dq_pkg::M_DATA_W-1:0] m_tdata,  // error_code, octet_a..d
  output logic                          m_tuser   // is_valid
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ZERO   = 3'd1,
    PH_OCT    = 3'd2,
    PH_HEXPRE = 3'd3,
    PH_HEX    = 3'd4,
    PH_DEC    = 3'd5
  } phase_t;

  localparam int unsigned EW = ipv4dq_pkg::ERR_W;
  localparam int unsigned OW = ipv4dq_pkg::OCTET_W;

  phase_t                 phase, phase_next;
  logic                   in_tok, in_tok_next;
  logic [2:0]             parts_done, parts_next;
  logic [8:0]             acc, acc_next;
  logic [EW-1:0]          sticky, sticky_next;
  logic [OW-1:0]          octets [4];
  logic [OW-1:0]          octets_next [4];

  logic                   out_valid;
  logic                   out_is_valid;
  logic [EW-1:0]          out_err;
  logic [OW-1:0]          out_oct [4];

  logic [EW-1:0]          fin_err;
  logic [12:0]            acc_scaled;
  logic [12:0]            acc_sum;
  logic [8:0]             acc_sat;
  logic [4:0]             d;
  logic                   term_pop;
  logic [EW-1:0]          res_err;
  logic [2:0]             res_parts;
  logic [OW-1:0]          res_oct [4];

  assign d        = head_item.digit;
  assign pop      = head_valid && (!head_item.term || !out_valid || m_tready);
  assign term_pop = pop && head_item.term;

  // outcome of closing the current token
  always_comb begin
    if (phase == PH_HEXPRE) begin
      fin_err = ipv4dq_pkg::ERR_BADCHAR;
    end else if (acc > 9'd255) begin
      fin_err = ipv4dq_pkg::ERR_RANGE;
    end else begin
      fin_err = ipv4dq_pkg::ERR_NONE;
    end
  end

  // acc * base + digit, saturating at 256
  always_comb begin
    unique case (phase) inside
      PH_OCT:            acc_scaled = {1'b0, acc, 3'b000};
      PH_HEXPRE, PH_HEX: acc_scaled = {acc, 4'b0000};
      default:           acc_scaled = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
    endcase
    acc_sum = acc_scaled + 13'(d);
    acc_sat = (acc_sum > 13'd255) ? 9'd256 : acc_sum[8:0];
  end

  // verdict on a terminator
  always_comb begin
    res_parts = parts_done;
    for (int k = 0; k < 4; k++) begin
      res_oct[k] = octets[k];
    end
    if (sticky != ipv4dq_pkg::ERR_NONE) begin
      res_err = sticky;
    end else if (in_tok && fin_err != ipv4dq_pkg::ERR_NONE) begin
      res_err = fin_err;
    end else begin
      if (in_tok) begin
        res_oct[parts_done[1:0]] = acc[7:0];
        res_parts = parts_done + 3'd1;
      end
      res_err = (res_parts < 3'd4) ? ipv4dq_pkg::ERR_FEW : ipv4dq_pkg::ERR_NONE;
    end
  end

  always_comb begin
    phase_next  = phase;
    in_tok_next = in_tok;
    parts_next  = parts_done;
    acc_next    = acc;
    sticky_next = sticky;
    for (int k = 0; k < 4; k++) begin
      octets_next[k] = octets[k];
    end
    if (term_pop) begin
      phase_next  = PH_IDLE;
      in_tok_next = 1'b0;
      parts_next  = '0;
      acc_next    = '0;
      sticky_next = ipv4dq_pkg::ERR_NONE;
      for (int k = 0; k < 4; k++) begin
        octets_next[k] = '0;
      end
    end else if (pop && sticky == ipv4dq_pkg::ERR_NONE) begin
      if (head_item.dot) begin
        if (in_tok) begin
          if (fin_err != ipv4dq_pkg::ERR_NONE) begin
            sticky_next = fin_err;
          end else begin
            octets_next[parts_done[1:0]] = acc[7:0];
            parts_next = parts_done + 3'd1;
          end
          in_tok_next = 1'b0;
          phase_next  = PH_IDLE;
          acc_next    = '0;
        end
      end else if (!in_tok) begin
        if (parts_done >= 3'd4) begin
          sticky_next = ipv4dq_pkg::ERR_MANY;
        end else if (d > 5'd9) begin
          sticky_next = ipv4dq_pkg::ERR_NOTDIGIT;
        end else begin
          in_tok_next = 1'b1;
          phase_next  = (d == 5'd0) ? PH_ZERO : PH_DEC;
          acc_next    = 9'(d);
        end
      end else begin
        unique case (phase) inside
          PH_ZERO: begin
            if (head_item.is_x) begin
              phase_next = PH_HEXPRE;
            end else if (d < 5'd8) begin
              phase_next = PH_OCT;
              acc_next   = 9'(d);
            end else begin
              sticky_next = ipv4dq_pkg::ERR_BADCHAR;
            end
          end
          PH_OCT: begin
            if (d < 5'd8) acc_next = acc_sat;
            else sticky_next = ipv4dq_pkg::ERR_BADCHAR;
          end
          PH_HEXPRE, PH_HEX: begin
            if (d < 5'd16) begin
              acc_next   = acc_sat;
              phase_next = PH_HEX;
            end else begin
              sticky_next = ipv4dq_pkg::ERR_BADCHAR;
            end
          end
          PH_DEC: begin
            if (d < 5'd10) acc_next = acc_sat;
            else sticky_next = ipv4dq_pkg::ERR_BADCHAR;
          end
          default: sticky_next = ipv4dq_pkg::ERR_BADCHAR;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      in_tok       <= 1'b0;
      parts_done   <= '0;
      acc          <= '0;
      sticky       <= ipv4dq_pkg::ERR_NONE;
      for (int k = 0; k < 4; k++) begin
        octets[k]  <= '0;
        out_oct[k] <= '0;
      end
      out_valid    <= 1'b0;
      out_is_valid <= 1'b0;
      out_err      <= ipv4dq_pkg::ERR_NONE;
    end else begin
      phase      <= phase_next;
      in_tok     <= in_tok_next;
      parts_done <= parts_next;
      acc        <= acc_next;
      sticky     <= sticky_next;
      for (int k = 0; k < 4; k++) begin
        octets[k] <= octets_next[k];
      end
      // verdict payload loads with the terminator
      if (term_pop) begin
        out_valid    <= 1'b1;
        out_is_valid <= (res_err == ipv4dq_pkg::ERR_NONE);
        out_err      <= res_err;
        for (int k = 0; k < 4; k++) begin
          out_oct[k] <= (res_err == ipv4dq_pkg::ERR_NONE) ? res_oct[k] : '0;
        end
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_is_valid;
  assign m_tdata  = {5'b00000, out_oct[3], out_oct[2], out_oct[1], out_oct[0], out_err};

`ifndef SYNTHESIS
  a_parts_bound: assert property (@(posedge clk) disable iff (rst)
    parts_done <= 3'd4)
    else $error("part count beyond four");

  a_valid_no_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_is_valid |-> out_err == ipv4dq_pkg::ERR_NONE)
    else $error("valid verdict with error code");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_is_valid |-> out_oct[0] == '0 && out_oct[3] == '0)
    else $error("octets not cleared on failed verdict");

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    term_pop |=> parts_done == '0 && !in_tok && sticky == ipv4dq_pkg::ERR_NONE)
    else $error("state not cleared after terminator");
`endif

endmodule

/* tb/sv/tb_ipv4_dotted_quad_parser.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ipv4_dotted_quad_parser
// Self-checking bench for the dotted-quad address parser.
// ----------------------------------------------------------------------------
// Strings go in one character word at a time. Each accepted word is run
// through a behavioural parser in the bench, and each terminator queues the
// verdict it should produce. Verdict words coming out are compared field by
// field with the oldest queued verdict. A short directed set comes first,
// then random strings, mostly well-formed with random numbers, bases and dot
// runs, some corrupted, some pure noise. Phases vary the sender gaps and the
// receiver stalls, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_ipv4_dotted_quad_parser;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned RANDOM_WORDS   = 40;  // per phase

  typedef enum logic [2:0] {
    RX_IDLE, RX_ZERO, RX_OCT, RX_HEXPRE, RX_HEX, RX_DEC
  } radix_t;

  typedef struct packed {
    logic                                                   ok;
    logic [ipv4dq_pkg::ERR_W-1:0]                           code;
    logic [ipv4dq_pkg::OCTETS-1:0][ipv4dq_pkg::OCTET_W-1:0] octets;
  } verdict_t;

  logic                            clk      = 1'b0;
  logic                            rst      = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [7:0]                      s_tdata  = '0;
  logic                            s_tlast  = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [ipv4dq_pkg::M_DATA_W-1:0] m_tdata;
  logic                            m_tuser;

  // pending character words: {last, ch}
  logic [8:0]  char_words[$];
  logic [7:0]  draft[$];
  verdict_t    verdict_q[$];

  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned holds_requested = 0;
  int unsigned holds_granted   = 0;
  int unsigned hold_left       = 0;
  int unsigned words_queued    = 0;
  int unsigned mismatches      = 0;
  int unsigned quiet_cycles    = 0;

  // parser state of the bench
  logic [2:0]                                             pd_parts;
  logic                                                   pd_in_tok;
  radix_t                                                 pd_phase;
  logic [8:0]                                             pd_acc;
  logic [ipv4dq_pkg::OCTETS-1:0][ipv4dq_pkg::OCTET_W-1:0] pd_octets;
  logic [ipv4dq_pkg::ERR_W-1:0]                           pd_err;

  ipv4_dotted_quad_parser DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- parser
  function automatic logic [ipv4dq_pkg::DIGIT_W-1:0] char_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return ipv4dq_pkg::DIGIT_W'(c - "0");
    if (c >= "a" && c <= "f") return ipv4dq_pkg::DIGIT_W'(c - "a" + 10);
    if (c >= "A" && c <= "F") return ipv4dq_pkg::DIGIT_W'(c - "A" + 10);
    return ipv4dq_pkg::NOT_DIGIT;
  endfunction

  function automatic void clear_token();
    pd_in_tok = 1'b0;
    pd_phase  = RX_IDLE;
    pd_acc    = '0;
  endfunction

  function automatic void clear_parser();
    clear_token();
    pd_parts  = '0;
    pd_octets = '0;
    pd_err    = ipv4dq_pkg::ERR_NONE;
  endfunction

  // saturates at 256
  function automatic void shift_in(int unsigned base, logic [ipv4dq_pkg::DIGIT_W-1:0] d);
    int unsigned v;
    v = pd_acc * base + d;
    pd_acc = (v > 255) ? 9'd256 : 9'(v);
  endfunction

  function automatic void close_token();
    if (pd_phase == RX_HEXPRE)
      pd_err = ipv4dq_pkg::ERR_BADCHAR;
    else if (pd_acc > 255)
      pd_err = ipv4dq_pkg::ERR_RANGE;
    else begin
      pd_octets[pd_parts[1:0]] = pd_acc[7:0];
      pd_parts = pd_parts + 3'd1;
    end
    clear_token();
  endfunction

  function automatic void parse_char(logic [7:0] c);
    logic [ipv4dq_pkg::DIGIT_W-1:0] d;
    d = char_digit(c);
    if (c == ".") begin
      if (pd_in_tok) close_token();
    end else if (!pd_in_tok) begin
      if (pd_parts >= 4)
        pd_err = ipv4dq_pkg::ERR_MANY;
      else if (d > 9)
        pd_err = ipv4dq_pkg::ERR_NOTDIGIT;
      else begin
        pd_in_tok = 1'b1;
        pd_phase  = (d == 0) ? RX_ZERO : RX_DEC;
        pd_acc    = 9'(d);
      end
    end else begin
      case (pd_phase) inside
        RX_ZERO: begin
          if (c == "x" || c == "X")
            pd_phase = RX_HEXPRE;
          else if (d < 8) begin
            pd_phase = RX_OCT;
            pd_acc   = 9'(d);
          end else
            pd_err = ipv4dq_pkg::ERR_BADCHAR;
        end
        RX_OCT: begin
          if (d < 8) shift_in(8, d); else pd_err = ipv4dq_pkg::ERR_BADCHAR;
        end
        RX_HEXPRE, RX_HEX: begin
          if (d < 16) begin
            shift_in(16, d);
            pd_phase = RX_HEX;
          end else
            pd_err = ipv4dq_pkg::ERR_BADCHAR;
        end
        RX_DEC: begin
          if (d < 10) shift_in(10, d); else pd_err = ipv4dq_pkg::ERR_BADCHAR;
        end
        default: pd_err = ipv4dq_pkg::ERR_BADCHAR;
      endcase
    end
  endfunction

  function automatic void parse_word(logic [7:0] c, logic last);
    verdict_t v;
    if (!last && c != 8'd0) begin
      if (pd_err == ipv4dq_pkg::ERR_NONE) parse_char(c);
    end else begin
      if (pd_err == ipv4dq_pkg::ERR_NONE && pd_in_tok) close_token();
      if (pd_err == ipv4dq_pkg::ERR_NONE && pd_parts < 4) pd_err = ipv4dq_pkg::ERR_FEW;
      v.ok     = (pd_err == ipv4dq_pkg::ERR_NONE);
      v.code   = pd_err;
      v.octets = v.ok ? pd_octets : '0;
      verdict_q.push_back(v);
      clear_parser();
    end
  endfunction

  // ------------------------------------------------------------- stimulus
  function automatic void push_word(logic [7:0] c, logic last);
    char_words.push_back({last, c});
    words_queued++;
  endfunction

  // either a flagged word with any byte, or a plain zero byte
  function automatic void push_terminator();
    if ($urandom_range(1)) push_word(8'($urandom_range(255)), 1'b1);
    else push_word(8'd0, 1'b0);
  endfunction

  function automatic void emit_draft();
    foreach (draft[i]) push_word(draft[i], 1'b0);
    push_terminator();
    draft.delete();
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
    emit_draft();
  endfunction

  function automatic logic [7:0] noise_byte();
    string pool;
    pool = "0189.xXaAfFgG";
    if ($urandom_range(1)) return pool[$urandom_range(pool.len() - 1)];
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic void draft_number(int unsigned v, int unsigned base);
    logic [7:0]  digs[$];
    int unsigned d;
    if (base == 16) begin
      draft.push_back("0");
      draft.push_back($urandom_range(1) ? "X" : "x");
    end else if (base == 8)
      draft.push_back("0");
    if (base != 10 && $urandom_range(3) == 0)
      repeat ($urandom_range(1, 2)) draft.push_back("0");
    do begin
      d = v % base;
      v = v / base;
      if (d < 10) digs.push_front(8'("0" + d));
      else digs.push_front($urandom_range(1) ? 8'("A" + d - 10) : 8'("a" + d - 10));
    end while (v != 0);
    foreach (digs[i]) draft.push_back(digs[i]);
  endfunction

  function automatic void queue_random_string();
    int unsigned roll, parts, base;
    roll = $urandom_range(99);
    if (roll < 10) begin
      repeat ($urandom_range(8)) draft.push_back(noise_byte());
    end else begin
      parts = ($urandom_range(99) < 70) ? 4 : $urandom_range(1, 6);
      if ($urandom_range(9) == 0) draft.push_back(".");
      for (int k = 0; k < parts; k++) begin
        if (k != 0)
          repeat (($urandom_range(6) == 0) ? $urandom_range(2, 3) : 1) draft.push_back(".");
        case ($urandom_range(3))
          0:       base = 8;
          1:       base = 16;
          default: base = 10;
        endcase
        draft_number(($urandom_range(99) < 85) ? $urandom_range(255) : $urandom_range(4095),
                     base);
      end
      if ($urandom_range(9) == 0) repeat ($urandom_range(1, 2)) draft.push_back(".");
      if (roll < 25) draft[$urandom_range(draft.size() - 1)] = noise_byte();
    end
    emit_draft();
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tlast  <= 1'b0;
      clear_parser();
    end else begin
      if (s_tvalid && s_tready) parse_word(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (char_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          {s_tlast, s_tdata} <= char_words.pop_front();
          s_tvalid <= 1'b1;
        end else
          s_tvalid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= (hold_left == 1);
    end else if (holds_requested > holds_granted) begin
      holds_granted <= holds_granted + 1;
      hold_left     <= HOLD_CYCLES;
      m_tready      <= 1'b0;
    end else
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------- monitor
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: verdict word with none expected (data %h)", $realtime, m_tdata);
      end else begin
        want = verdict_q.pop_front();
        check_field("is_valid", want.ok, m_tuser);
        check_field("error_code", want.code, m_tdata[2:0]);
        for (int k = 0; k < ipv4dq_pkg::OCTETS; k++)
          check_field($sformatf("octet %0d", k), want.octets[k], m_tdata[3 + 8 * k +: 8]);
        check_field("padding", 0, m_tdata[ipv4dq_pkg::M_DATA_W-1:35]);
      end
    end
  end

  // -------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ------------------------------------------------------------- sequence
  task automatic drain();
    while (char_words.size() != 0 || s_tvalid || verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(int unsigned idle_pct, int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    words_queued   = 0;
    while (words_queued < RANDOM_WORDS) queue_random_string();
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed strings, no idling
    queue_text("255.0xff.0377.0");
    queue_text("0.0.0.0");
    queue_text(".1..2...3.4.");
    queue_text("0X1F.010.0x0.00");
    queue_text("a.1.2.3");
    queue_text("1.2.3.4.5");
    queue_text("256.1.1.0400");
    queue_text("1.0x1ff.1.1");
    queue_text("1.2.3.0x");         // hex prefix, no digits, at terminator
    queue_text("0x.1.2.3");         // hex prefix ended by a dot
    queue_text("0xg.1.1.1");
    queue_text("08.1.1.1");
    queue_text("99999999z.1.1.1");  // bad character wins over range
    queue_text("1.2.3");
    queue_text("12a.5.5.5.");       // rest ignored after an error
    draft.push_back(8'hc8);
    queue_text(".1.1.1");           // high byte starting a token
    draft.push_back("1");
    draft.push_back(8'hff);
    emit_draft();                   // high byte inside a token
    push_word(8'd0, 1'b0);          // empty string, zero byte
    queue_text("10.20.30.40");
    push_word("7", 1'b1);           // flagged terminator, byte ignored
    drain();

    // long hold-off on the output while short strings keep coming
    holds_requested = 1;
    repeat (6) begin
      push_terminator();
      queue_text("1.2.3.4");
    end
    drain();

    random_phase(0, 0);
    random_phase(65, 0);
    random_phase(0, 65);
    random_phase(15, 15);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/ipv4dq_pkg.sv
rtl/ipv4dq_front.sv
rtl/ipv4dq_queue.sv
rtl/ipv4dq_back.sv
rtl/ipv4_dotted_quad_parser.sv
tb/sv/tb_ipv4_dotted_quad_parser.sv
